// ===== rtl/keyframe_track_interpolator_assert.svh =====
// Assertion macros shared by the keyframe track interpolator RTL.
// Needs signals named clk and rst_n in the scope where a macro is used.
`ifndef KEYFRAME_TRACK_INTERPOLATOR_ASSERT_SVH
`define KEYFRAME_TRACK_INTERPOLATOR_ASSERT_SVH

// Implication checked in the following cycle, disabled during reset.
`define KTI_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("keyframe track interpolator: assertion failed");

// Condition that must hold at every clock edge out of reset.
`define KTI_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("keyframe track interpolator: assertion failed");

`endif

// ===== rtl/kti_pkg.sv =====
// Package for the keyframe track interpolator: keyframe ROM, types and constants.
// No dependencies; the top level, kti_sine and kti_blend refer to it by scoped names.
`timescale 1ns / 1ps

package kti_pkg;

  localparam int ROM_ROWS     = 5;
  localparam int KEY_IDX_W    = 3;
  // Keyframes sit at even steps of six seconds, Q16.16.
  localparam int KEY_STEP_Q16 = 6 * 65536;
  localparam int WIDE_LANES   = 7;
  localparam int COLOR_LANES  = 6;
  localparam int WIDE_W       = 17;
  localparam int ALPHA_W      = 17;

  // Lane order of the wide values.
  localparam int LANE_ROT_X   = 0;
  localparam int LANE_ROT_Y   = 1;
  localparam int LANE_ROT_Z   = 2;
  localparam int LANE_SHIFT_X = 3;
  localparam int LANE_SHIFT_Y = 4;
  localparam int LANE_SHIFT_Z = 5;
  localparam int LANE_VIEW    = 6;

  localparam logic [ALPHA_W-1:0] ALPHA_ONE = 17'd65536;
  // Reciprocal of six in Q0.22: exact quotient for values below 2^19.
  localparam logic [19:0] ALPHA_RECIP = 20'd699051;

  // Phase step 0.85/(2*pi) in Q0.32.
  localparam logic [29:0] PHASE_K = 30'd581030485;
  localparam logic [14:0] SIN_A   = 15'd25736;
  localparam logic [13:0] SIN_B   = 14'd10512;
  localparam logic [10:0] SIN_C   = 11'd1160;
  localparam logic [12:0] GAIN_SHIFT = 13'd6554;
  localparam logic [12:0] GAIN_ROT   = 13'd7864;

  typedef logic [KEY_IDX_W-1:0] key_idx_t;

  // Colour lanes: fill R, G, B in lanes 5..3, wire R, G, B in lanes 2..0.
  typedef struct packed {
    logic [WIDE_LANES-1:0][WIDE_W-1:0] wide;
    logic [COLOR_LANES-1:0][7:0]       color;
    logic                              show_fill;
    logic                              show_wire;
  } key_t;

  // Blended values before the pulse and the final saturation.
  typedef struct packed {
    logic [WIDE_LANES-1:0][17:0] wide;
    logic [COLOR_LANES-1:0][7:0] color;
    logic                        show_fill;
    logic                        show_wire;
  } blend_t;

  function automatic key_t key_rom(key_idx_t idx);
    key_t k;
    k = '0;
    unique case (idx)
      3'd0: begin
        k.wide  = {17'sd18432, 17'sd10650, 17'sd0, 17'sd0, 17'sd0, 17'sd0, 17'sd0};
        k.color = {24'h2A4CC8, 24'h93E8FF};
        k.show_fill = 1'b1;
        k.show_wire = 1'b1;
      end
      3'd1: begin
        k.wide  = {17'sd16896, 17'sd9216, 17'sd410, 17'sd0,
                   17'sd2048, 17'sd4506, 17'sd6144};
        k.color = {24'h4F67DA, 24'hC4F2FF};
        k.show_fill = 1'b1;
        k.show_wire = 1'b1;
      end
      3'd2: begin
        k.wide  = {17'sd14336, 17'sd7782, -17'sd410, 17'sd0,
                   17'sd4506, 17'sd9011, 17'sd11059};
        k.color = {24'hC06A2C, 24'hF8CC9F};
        k.show_fill = 1'b1;
        k.show_wire = 1'b0;
      end
      3'd3: begin
        k.wide  = {17'sd16384, 17'sd9626, 17'sd0, 17'sd0,
                   17'sd8602, 17'sd12288, 17'sd14746};
        k.color = {24'h3BA67D, 24'hA9FFE2};
        k.show_fill = 1'b1;
        k.show_wire = 1'b1;
      end
      3'd4: begin
        k.wide  = {17'sd18944, 17'sd11059, 17'sd0, 17'sd0,
                   17'sd12698, 17'sd17203, 17'sd21299};
        k.color = {24'h3345B0, 24'h90DFF9};
        k.show_fill = 1'b1;
        k.show_wire = 1'b1;
      end
      default: begin
        k = '0;
      end
    endcase
    return k;
  endfunction

  function automatic logic [15:0] sat_s16(logic signed [18:0] v);
    logic [15:0] r;
    priority if (v < -19'sd32768) begin
      r = 16'h8000;
    end else if (v > 19'sd32767) begin
      r = 16'h7FFF;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  function automatic logic [15:0] sat_u16(logic signed [18:0] v);
    logic [15:0] r;
    priority if (v < 19'sd0) begin
      r = 16'h0000;
    end else if (v > 19'sd65535) begin
      r = 16'hFFFF;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/kti_in_if.sv =====
// Input channel of the keyframe track interpolator: one time word per handshake.
// No dependencies.
`timescale 1ns / 1ps

interface kti_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] time_q16;

  modport source (output valid, output time_q16, input ready);
  modport sink   (input valid, input time_q16, output ready);
endinterface

// ===== rtl/kti_out_if.sv =====
// Result channel of the keyframe track interpolator: one pose word per handshake.
// No dependencies.
`timescale 1ns / 1ps

interface kti_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] rotation_x;
  logic signed [15:0] rotation_y;
  logic signed [15:0] rotation_z;
  logic signed [15:0] shift_x;
  logic signed [15:0] shift_y;
  logic signed [15:0] shift_z;
  logic        [15:0] view_angle;
  logic        [31:0] fill_argb;
  logic        [31:0] wire_argb;
  logic               show_fill;
  logic               show_wire;

  modport source (output valid, output rotation_x, output rotation_y, output rotation_z,
                  output shift_x, output shift_y, output shift_z, output view_angle,
                  output fill_argb, output wire_argb, output show_fill, output show_wire,
                  input ready);
  modport sink   (input valid, input rotation_x, input rotation_y, input rotation_z,
                  input shift_x, input shift_y, input shift_z, input view_angle,
                  input fill_argb, input wire_argb, input show_fill, input show_wire,
                  output ready);
endinterface

// ===== rtl/keyframe_track_interpolator.sv =====
// Keyframe track interpolator: top level with pipeline control and output register.
// Depends on kti_pkg, kti_in_if, kti_out_if, kti_wrap, kti_sine, kti_blend and the
// assertion macro header.
`timescale 1ns / 1ps
//
// Usage. The input channel carries one word per handshake: a signed Q16.16 time.
// The result channel returns one pose word for every accepted time word, in order:
// rotation and translation in Q4.12, view angle in Q8.8, two ARGB colours and two
// draw flags. A word is accepted on a rising edge where valid and ready are high.
//
// There are ten register stages: a time word accepted at one edge passes through them
// in order and is presented on the result channel from the output register.
// Throughput is one word per cycle while the receiver does not stall: each of the ten
// stages (time wrap, search and sine polynomial, blend, output) then takes a new word.
//
// Each stage carries a valid bit and loads whenever it is empty or the stage after
// it moves, so bubbles close up. When the receiver stalls, the output register holds
// its word and the stages behind it keep filling; input ready falls only once every
// stage holds a word. Reset clears every valid bit at once; the datapath keeps no
// other state, so the block is ready as soon as reset ends.
//
`include "keyframe_track_interpolator_assert.svh"

module keyframe_track_interpolator #(
  parameter int KEY_COUNT  = 5,
  parameter int LOOP_LEN_S = 24
) (
  input  logic      clk,
  input  logic      rst_n,
  kti_in_if.sink    in_chan,
  kti_out_if.source out_chan
);

  localparam int STAGES = 10;
  localparam int LAST   = STAGES - 1;

  logic [STAGES-1:0] vld_r, vld_nxt;
  logic [STAGES-1:0] adv;

  logic [30:0]        wrap_q16;
  logic signed [10:0] pulse_rot, pulse_shift;
  kti_pkg::blend_t    blend;

  logic signed [18:0] rot_z_sum, shift_y_sum;

  logic [15:0] rot_x_r, rot_y_r, rot_z_r;
  logic [15:0] shift_x_r, shift_y_r, shift_z_r;
  logic [15:0] view_r;
  logic [31:0] fill_r, wire_r;
  logic        show_fill_r, show_wire_r;

  // A stage loads when it is empty or when the stage after it loads.
  always_comb begin
    adv[LAST] = !vld_r[LAST] || out_chan.ready;
    for (int k = LAST - 1; k >= 0; k--) begin
      adv[k] = !vld_r[k] || adv[k + 1];
    end
  end

  always_comb begin
    vld_nxt = vld_r;
    if (adv[0]) begin
      vld_nxt[0] = in_chan.valid;
    end
    for (int k = 1; k < STAGES; k++) begin
      if (adv[k]) begin
        vld_nxt[k] = vld_r[k - 1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_chan.ready = adv[0];

  kti_wrap #(
    .LOOP_LEN_S (LOOP_LEN_S)
  ) u_wrap (
    .clk      (clk),
    .adv      (adv[2:0]),
    .time_q16 (in_chan.time_q16),
    .wrap_q16 (wrap_q16)
  );

  kti_sine u_sine (
    .clk         (clk),
    .adv         (adv[8:3]),
    .wrap_q16    (wrap_q16),
    .pulse_rot   (pulse_rot),
    .pulse_shift (pulse_shift)
  );

  kti_blend #(
    .KEY_COUNT (KEY_COUNT)
  ) u_blend (
    .clk      (clk),
    .adv      (adv[8:3]),
    .wrap_q16 (wrap_q16),
    .blend    (blend)
  );

  // The pulse rides on rotation about z and on translation y; everything saturates.
  assign rot_z_sum   = 19'($signed(blend.wide[kti_pkg::LANE_ROT_Z])) + 19'(pulse_rot);
  assign shift_y_sum = 19'($signed(blend.wide[kti_pkg::LANE_SHIFT_Y])) + 19'(pulse_shift);

  always_ff @(posedge clk) begin
    if (adv[LAST]) begin
      rot_x_r     <= kti_pkg::sat_s16(19'($signed(blend.wide[kti_pkg::LANE_ROT_X])));
      rot_y_r     <= kti_pkg::sat_s16(19'($signed(blend.wide[kti_pkg::LANE_ROT_Y])));
      rot_z_r     <= kti_pkg::sat_s16(rot_z_sum);
      shift_x_r   <= kti_pkg::sat_s16(19'($signed(blend.wide[kti_pkg::LANE_SHIFT_X])));
      shift_y_r   <= kti_pkg::sat_s16(shift_y_sum);
      shift_z_r   <= kti_pkg::sat_s16(19'($signed(blend.wide[kti_pkg::LANE_SHIFT_Z])));
      view_r      <= kti_pkg::sat_u16(19'($signed(blend.wide[kti_pkg::LANE_VIEW])));
      fill_r      <= {8'hFF, blend.color[5], blend.color[4], blend.color[3]};
      wire_r      <= {8'hFF, blend.color[2], blend.color[1], blend.color[0]};
      show_fill_r <= blend.show_fill;
      show_wire_r <= blend.show_wire;
    end
  end

  assign out_chan.valid      = vld_r[LAST];
  assign out_chan.rotation_x = rot_x_r;
  assign out_chan.rotation_y = rot_y_r;
  assign out_chan.rotation_z = rot_z_r;
  assign out_chan.shift_x    = shift_x_r;
  assign out_chan.shift_y    = shift_y_r;
  assign out_chan.shift_z    = shift_z_r;
  assign out_chan.view_angle = view_r;
  assign out_chan.fill_argb  = fill_r;
  assign out_chan.wire_argb  = wire_r;
  assign out_chan.show_fill  = show_fill_r;
  assign out_chan.show_wire  = show_wire_r;

  // An accepted word always lands in the first stage.
  `KTI_ASSERT_NEXT(a_accept_enters, in_chan.valid && in_chan.ready, vld_r[0])
  // With the output register empty nothing can hold the input back.
  `KTI_ASSERT_ALWAYS(a_ready_when_drained, vld_r[LAST] || in_chan.ready)
  // A word waiting behind a stalled output is kept, not dropped.
  `KTI_ASSERT_NEXT(a_stall_keeps, vld_r[LAST - 1] && vld_r[LAST] && !out_chan.ready,
                   vld_r[LAST - 1])
  // Both colours always leave with an opaque alpha byte.
  `KTI_ASSERT_ALWAYS(a_opaque, !out_chan.valid ||
                     (fill_r[31:24] == 8'hFF && wire_r[31:24] == 8'hFF))

endmodule

// ===== rtl/kti_wrap.sv =====
// Three-stage wrap of a signed Q16.16 time into [0, loop length).
// Depends on nothing but its parameter; stage loads come from the top level.
`timescale 1ns / 1ps

module kti_wrap #(
  parameter int LOOP_LEN_S = 24
) (
  input  logic               clk,
  input  logic [2:0]         adv,
  input  logic signed [31:0] time_q16,
  output logic [30:0]        wrap_q16
);

  localparam int LOOP_S = (LOOP_LEN_S < 1) ? 1 : LOOP_LEN_S;
  localparam longint RECIP_L = ((longint'(1) <<< 32) + longint'(LOOP_S) - longint'(1))
                               / longint'(LOOP_S);
  localparam logic [32:0] MOD_RECIP = 33'(RECIP_L);
  localparam logic [14:0] LOOP_L    = 15'(LOOP_S);
  localparam logic [14:0] BIAS_REM  = 15'(32768 % LOOP_S);

  logic [15:0] biased;
  logic [48:0] mprod;
  logic [15:0] quot_r, u_r, lo0_r, lo1_r, lo2_unused;
  logic [30:0] ql;
  logic [15:0] rem_full;
  logic [14:0] rem_r;
  logic [15:0] diff;
  logic [14:0] wrapped_s;
  logic [30:0] wrap_r;

  // Whole seconds offset by 32768 so the reduction works on an unsigned value.
  assign biased = {~time_q16[31], time_q16[30:16]};
  assign mprod  = {33'd0, biased} * {16'd0, MOD_RECIP};

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      quot_r <= mprod[47:32];
      u_r    <= biased;
      lo0_r  <= time_q16[15:0];
    end
  end

  assign ql       = {15'd0, quot_r} * {16'd0, LOOP_L};
  assign rem_full = u_r - ql[15:0];

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      rem_r <= rem_full[14:0];
      lo1_r <= lo0_r;
    end
  end

  // Remove the offset again; the result is a floor modulo, so negative times wrap upward.
  assign diff      = {1'b0, rem_r} - {1'b0, BIAS_REM};
  assign wrapped_s = diff[15] ? 15'(diff[14:0] + LOOP_L) : diff[14:0];
  assign lo2_unused = lo1_r;

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      wrap_r <= {wrapped_s, lo2_unused};
    end
  end

  assign wrap_q16 = wrap_r;

endmodule

// ===== rtl/kti_sine.sv =====
// Six-stage pulse generator: phase from wrapped time, polynomial sine, pulse gains.
// Depends on kti_pkg for the polynomial and gain constants.
`timescale 1ns / 1ps

module kti_sine (
  input  logic               clk,
  input  logic [5:0]         adv,
  input  logic [30:0]        wrap_q16,
  output logic signed [10:0] pulse_rot,
  output logic signed [10:0] pulse_shift
);

  logic [60:0] ph_prod;
  logic [15:0] ph_r;
  logic [14:0] z_nxt;
  logic [29:0] zz;
  logic [14:0] z2_r, z2b_r;
  logic [14:0] z_r, zb_r, zc_r;
  logic        neg_r, negb_r, negc_r;
  logic [25:0] t1;
  logic [13:0] inner_r;
  logic [28:0] t2;
  logic [14:0] mid_r;
  logic [29:0] t3;
  logic signed [16:0] pulse_r;
  logic signed [31:0] rot_prod, shift_prod;
  logic signed [10:0] prot_r, pshift_r;

  assign ph_prod = {30'd0, wrap_q16} * {31'd0, kti_pkg::PHASE_K};

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      ph_r <= ph_prod[47:32];
    end
  end

  // Second quadrant and fourth mirror the quarter wave; the upper half negates it.
  assign z_nxt = ph_r[14] ? 15'(15'd16384 - {1'b0, ph_r[13:0]}) : {1'b0, ph_r[13:0]};
  assign zz    = {15'd0, z_nxt} * {15'd0, z_nxt};

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      z2_r  <= zz[28:14];
      z_r   <= z_nxt;
      neg_r <= ph_r[15];
    end
  end

  assign t1 = {11'd0, z2_r} * {15'd0, kti_pkg::SIN_C};

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      inner_r <= 14'(kti_pkg::SIN_B - t1[25:14]);
      z2b_r   <= z2_r;
      zb_r    <= z_r;
      negb_r  <= neg_r;
    end
  end

  assign t2 = {14'd0, z2b_r} * {15'd0, inner_r};

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      mid_r  <= 15'(kti_pkg::SIN_A - t2[28:14]);
      zc_r   <= zb_r;
      negc_r <= negb_r;
    end
  end

  assign t3 = {15'd0, zc_r} * {15'd0, mid_r};

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      pulse_r <= negc_r ? -$signed({1'b0, t3[29:14]}) : $signed({1'b0, t3[29:14]});
    end
  end

  assign rot_prod   = 32'(pulse_r) * 32'($signed({1'b0, kti_pkg::GAIN_ROT}));
  assign shift_prod = 32'(pulse_r) * 32'($signed({1'b0, kti_pkg::GAIN_SHIFT}));

  // Round to nearest with ties upward, Q14 times Q0.16 down to Q4.12.
  always_ff @(posedge clk) begin
    if (adv[5]) begin
      prot_r   <= 11'((rot_prod + 32'sd131072) >>> 18);
      pshift_r <= 11'((shift_prod + 32'sd131072) >>> 18);
    end
  end

  assign pulse_rot   = prot_r;
  assign pulse_shift = pshift_r;

endmodule

// ===== rtl/kti_blend.sv =====
// Six-stage keyframe search, blend factor and linear blend of all lanes.
// Depends on kti_pkg for the keyframe ROM and the blended record type.
`timescale 1ns / 1ps

module kti_blend #(
  parameter int KEY_COUNT = 5
) (
  input  logic                clk,
  input  logic [5:0]          adv,
  input  logic [30:0]         wrap_q16,
  output kti_pkg::blend_t     blend
);

  localparam int USED_KEYS = (KEY_COUNT < 2) ? 2 :
                             ((KEY_COUNT > kti_pkg::ROM_ROWS) ? kti_pkg::ROM_ROWS : KEY_COUNT);

  kti_pkg::key_idx_t pv_nxt, pv_r, pvb_r, pvc_r, pvd_r;
  logic [30:0] base_nxt, v_nxt;
  logic [18:0] vlow_r;
  logic        full_r, fullb_r;
  logic [38:0] vq;
  logic [16:0] quot_r;
  logic [kti_pkg::ALPHA_W-1:0] alpha_r;
  kti_pkg::key_t ka, kb, kc;
  logic signed [35:0] wprod_r [kti_pkg::WIDE_LANES];
  logic signed [26:0] cprod_r [kti_pkg::COLOR_LANES];
  logic signed [35:0] wprod_nxt [kti_pkg::WIDE_LANES];
  logic signed [26:0] cprod_nxt [kti_pkg::COLOR_LANES];
  kti_pkg::blend_t res_nxt, res_r, out_r;

  // Earlier keyframe: the one before the first key at or after the time, held
  // to the last pair beyond the final key.
  always_comb begin
    pv_nxt   = kti_pkg::key_idx_t'(USED_KEYS - 2);
    base_nxt = 31'((USED_KEYS - 2) * kti_pkg::KEY_STEP_Q16);
    for (int i = USED_KEYS - 1; i >= 1; i--) begin
      if (wrap_q16 <= 31'(i * kti_pkg::KEY_STEP_Q16)) begin
        pv_nxt   = kti_pkg::key_idx_t'(i - 1);
        base_nxt = 31'((i - 1) * kti_pkg::KEY_STEP_Q16);
      end
    end
    v_nxt = wrap_q16 - base_nxt;
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      pv_r   <= pv_nxt;
      vlow_r <= v_nxt[18:0];
      full_r <= (v_nxt >= 31'(kti_pkg::KEY_STEP_Q16));
    end
  end

  assign vq = {20'd0, vlow_r} * {19'd0, kti_pkg::ALPHA_RECIP};

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      quot_r  <= vq[38:22];
      fullb_r <= full_r;
      pvb_r   <= pv_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      alpha_r <= fullb_r ? kti_pkg::ALPHA_ONE : quot_r;
      pvc_r   <= pvb_r;
    end
  end

  assign ka = kti_pkg::key_rom(pvc_r);
  assign kb = kti_pkg::key_rom(kti_pkg::key_idx_t'(pvc_r + 1'b1));

  always_comb begin
    logic signed [17:0] wdiff;
    logic signed [8:0]  cdiff;
    for (int i = 0; i < kti_pkg::WIDE_LANES; i++) begin
      wdiff = 18'($signed(kb.wide[i])) - 18'($signed(ka.wide[i]));
      wprod_nxt[i] = 36'(wdiff * $signed({1'b0, alpha_r}));
    end
    for (int j = 0; j < kti_pkg::COLOR_LANES; j++) begin
      cdiff = $signed({1'b0, kb.color[j]}) - $signed({1'b0, ka.color[j]});
      cprod_nxt[j] = 27'(cdiff * $signed({1'b0, alpha_r}));
    end
  end

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      wprod_r <= wprod_nxt;
      cprod_r <= cprod_nxt;
      pvd_r   <= pvc_r;
    end
  end

  assign kc = kti_pkg::key_rom(pvd_r);

  // Motion lanes round to nearest, colour lanes truncate toward minus infinity.
  always_comb begin
    logic signed [10:0] csum;
    res_nxt = '0;
    for (int i = 0; i < kti_pkg::WIDE_LANES; i++) begin
      res_nxt.wide[i] = 18'($signed(kc.wide[i])) + 18'((wprod_r[i] + 36'sd32768) >>> 16);
    end
    for (int j = 0; j < kti_pkg::COLOR_LANES; j++) begin
      csum = $signed({3'b000, kc.color[j]}) + 11'(cprod_r[j] >>> 16);
      priority if (csum < 11'sd0) begin
        res_nxt.color[j] = 8'd0;
      end else if (csum > 11'sd255) begin
        res_nxt.color[j] = 8'd255;
      end else begin
        res_nxt.color[j] = csum[7:0];
      end
    end
    res_nxt.show_fill = kc.show_fill;
    res_nxt.show_wire = kc.show_wire;
  end

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      res_r <= res_nxt;
    end
  end

  // Alignment stage to meet the pulse path.
  always_ff @(posedge clk) begin
    if (adv[5]) begin
      out_r <= res_r;
    end
  end

  assign blend = out_r;

endmodule

// ===== tb/kti_tb_pkg.sv =====
// Testbench types for the keyframe track interpolator: the pose word layout.
// Depends on nothing; used by the pose checker.
`timescale 1ns / 1ps

package kti_tb_pkg;

  typedef struct {
    logic signed [15:0] rotation_x;
    logic signed [15:0] rotation_y;
    logic signed [15:0] rotation_z;
    logic signed [15:0] shift_x;
    logic signed [15:0] shift_y;
    logic signed [15:0] shift_z;
    logic        [15:0] view_angle;
    logic        [31:0] fill_argb;
    logic        [31:0] wire_argb;
    logic               show_fill;
    logic               show_wire;
  } pose_t;

endpackage

// ===== tb/kti_tb_if.sv =====
// Channel interfaces are taken from the RTL; this file holds nothing of its own.
// Kept so the testbench file list mirrors the house layout (package, interfaces, modules).
`timescale 1ns / 1ps

// ===== tb/kti_pose_checker.sv =====
// Pose checker: predicts each pose word from the accepted time words and compares.
// Depends on kti_tb_pkg and the channel interfaces kti_in_if and kti_out_if.
`timescale 1ns / 1ps

module kti_pose_checker #(
  parameter int KEY_COUNT  = 5,
  parameter int LOOP_LEN_S = 24
) (
  input  logic      clk,
  input  logic      rst_n,
  kti_in_if         in_chan,
  kti_out_if        out_chan,
  output int        fail_count,
  output int        pending
);

  typedef struct {
    longint when;
    longint rot[3];
    longint shf[3];
    longint view;
    logic [31:0] fill;
    logic [31:0] wire_c;
    logic sf;
    logic sw;
  } key_row_t;

  key_row_t            track_keys[5];
  kti_tb_pkg::pose_t   pose_queue[$];

  initial begin
    track_keys[0] = '{0, '{0, 0, 0}, '{0, 0, 10650}, 18432,
                      32'hFF2A4CC8, 32'hFF93E8FF, 1'b1, 1'b1};
    track_keys[1] = '{6*65536, '{6144, 4506, 2048}, '{0, 410, 9216}, 16896,
                      32'hFF4F67DA, 32'hFFC4F2FF, 1'b1, 1'b1};
    track_keys[2] = '{12*65536, '{11059, 9011, 4506}, '{0, -410, 7782}, 14336,
                      32'hFFC06A2C, 32'hFFF8CC9F, 1'b1, 1'b0};
    track_keys[3] = '{18*65536, '{14746, 12288, 8602}, '{0, 0, 9626}, 16384,
                      32'hFF3BA67D, 32'hFFA9FFE2, 1'b1, 1'b1};
    track_keys[4] = '{24*65536, '{21299, 17203, 12698}, '{0, 0, 11059}, 18944,
                      32'hFF3345B0, 32'hFF90DFF9, 1'b1, 1'b1};
  end

  // Arithmetic shift of a signed value is a floor division by a power of two.
  function automatic longint mix_round(longint a, longint b, longint alpha);
    return a + (((b - a) * alpha + 32768) >>> 16);
  endfunction

  function automatic logic [7:0] mix_channel(longint a, longint b, longint alpha);
    longint v;
    v = a + (((b - a) * alpha) >>> 16);
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[7:0];
  endfunction

  function automatic logic [31:0] mix_colour(logic [31:0] a, logic [31:0] b,
                                             longint alpha);
    return {8'hFF, mix_channel(a[23:16], b[23:16], alpha),
            mix_channel(a[15:8], b[15:8], alpha), mix_channel(a[7:0], b[7:0], alpha)};
  endfunction

  function automatic longint quarter_wave(longint z);
    longint z2, inner, mid;
    z2 = (z * z) >> 14;
    inner = 10512 - ((z2 * 1160) >> 14);
    mid = 25736 - ((z2 * inner) >> 14);
    return (z * mid) >> 14;
  endfunction

  function automatic logic signed [15:0] clamp_s16(longint v);
    if (v < -32768) v = -32768;
    if (v > 32767) v = 32767;
    return v[15:0];
  endfunction

  function automatic kti_tb_pkg::pose_t predict_pose(logic signed [31:0] t_in);
    kti_tb_pkg::pose_t p;
    longint loop_q16, w, span, alpha, v, pulse, x, s, r;
    longint used;
    int nx, pv;
    logic [63:0] prod;
    logic [15:0] phase;
    loop_q16 = (LOOP_LEN_S < 1 ? 1 : LOOP_LEN_S) * 65536;
    used = KEY_COUNT < 2 ? 2 : (KEY_COUNT > 5 ? 5 : KEY_COUNT);
    w = longint'(t_in) % loop_q16;
    if (w < 0) w += loop_q16;
    nx = 1;
    while (nx < used && track_keys[nx].when < w) nx++;
    if (nx >= used) nx = used - 1;
    pv = nx - 1;
    span = track_keys[nx].when - track_keys[pv].when;
    if (span < 66) span = 66;
    v = w - track_keys[pv].when;
    if (v <= 0) alpha = 0;
    else begin
      alpha = (v * 65536) / span;
      if (alpha > 65536) alpha = 65536;
    end
    prod = 64'(w) * 64'd581030485;
    phase = prod[47:32];
    x = phase[13:0];
    pulse = phase[14] ? quarter_wave(16384 - x) : quarter_wave(x);
    if (phase[15]) pulse = -pulse;
    r = mix_round(track_keys[pv].rot[2], track_keys[nx].rot[2], alpha)
        + ((pulse * 7864 + 131072) >>> 18);
    s = mix_round(track_keys[pv].shf[1], track_keys[nx].shf[1], alpha)
        + ((pulse * 6554 + 131072) >>> 18);
    p.rotation_x = clamp_s16(mix_round(track_keys[pv].rot[0], track_keys[nx].rot[0], alpha));
    p.rotation_y = clamp_s16(mix_round(track_keys[pv].rot[1], track_keys[nx].rot[1], alpha));
    p.rotation_z = clamp_s16(r);
    p.shift_x = clamp_s16(mix_round(track_keys[pv].shf[0], track_keys[nx].shf[0], alpha));
    p.shift_y = clamp_s16(s);
    p.shift_z = clamp_s16(mix_round(track_keys[pv].shf[2], track_keys[nx].shf[2], alpha));
    v = mix_round(track_keys[pv].view, track_keys[nx].view, alpha);
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    p.view_angle = v[15:0];
    p.fill_argb = mix_colour(track_keys[pv].fill, track_keys[nx].fill, alpha);
    p.wire_argb = mix_colour(track_keys[pv].wire_c, track_keys[nx].wire_c, alpha);
    p.show_fill = track_keys[pv].sf;
    p.show_wire = track_keys[pv].sw;
    return p;
  endfunction

  task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      fail_count++;
      $display("%0t: %s expected %h, actual %h", $time, name, want, got);
    end
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    kti_tb_pkg::pose_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (pose_queue.size() == 0) begin
        fail_count++;
        $display("%0t: pose word with none expected, actual rotation_x %h", $time,
                 out_chan.rotation_x);
      end else begin
        want = pose_queue.pop_front();
        compare_field("rotation_x", want.rotation_x, out_chan.rotation_x);
        compare_field("rotation_y", want.rotation_y, out_chan.rotation_y);
        compare_field("rotation_z", want.rotation_z, out_chan.rotation_z);
        compare_field("shift_x", want.shift_x, out_chan.shift_x);
        compare_field("shift_y", want.shift_y, out_chan.shift_y);
        compare_field("shift_z", want.shift_z, out_chan.shift_z);
        compare_field("view_angle", want.view_angle, out_chan.view_angle);
        compare_field("fill_argb", want.fill_argb, out_chan.fill_argb);
        compare_field("wire_argb", want.wire_argb, out_chan.wire_argb);
        compare_field("show_fill", want.show_fill, out_chan.show_fill);
        compare_field("show_wire", want.show_wire, out_chan.show_wire);
      end
    end
    if (rst_n && in_chan.valid && in_chan.ready)
      pose_queue.push_back(predict_pose(in_chan.time_q16));
    pending = pose_queue.size();
  end

endmodule

// ===== tb/tb.sv =====
// Testbench top for the keyframe track interpolator: clock, reset, stimulus and verdict.
// Depends on the RTL (package, interfaces, block) and on kti_pose_checker.
`timescale 1ns / 1ps

module tb;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending;

  kti_in_if  in_chan ();
  kti_out_if out_chan ();

  keyframe_track_interpolator u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  kti_pose_checker u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .out_chan   (out_chan),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Idle and stall percentages for the current phase; 0 means never.
  int send_idle_pct;
  int recv_stall_pct;
  // While set, the receiver holds off entirely so the pipeline fills and backs up.
  bit hold_off;

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // The receiver decides its ready for the next cycle at every rising edge.
  initial out_chan.ready = 1'b0;
  always @(posedge clk) begin
    if (!rst_n || hold_off) begin
      out_chan.ready <= 1'b0;
    end else begin
      out_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Long receiver hold-off, counted in its own process, while the sender keeps going.
  task automatic long_hold_off(int cycles);
    hold_off = 1'b1;
    repeat (cycles) @(posedge clk);
    hold_off = 1'b0;
  endtask

  // Offer one time word, with random idle cycles before it, and wait for acceptance.
  task automatic send_time(logic signed [31:0] t);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid    <= 1'b1;
    in_chan.time_q16 <= t;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
  endtask

  // Random time: mostly within 25 loops of zero, some anywhere in the 32-bit range,
  // some at or one step either side of keyframe boundaries.
  function automatic logic signed [31:0] random_time();
    int pick;
    pick = $urandom_range(99);
    if (pick < 15) return $urandom();
    if (pick < 35)
      return $signed($urandom_range(8) * 6 * 65536) - 24 * 65536 + $signed($urandom_range(2)) - 1;
    return $signed($urandom_range(50 * 24 * 65536)) - 25 * 24 * 65536;
  endfunction

  task automatic random_phase(int count, int idle_pct, int stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) send_time(random_time());
  endtask

  initial begin
    hold_off = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    rst_n = 1'b0;
    in_chan.valid = 1'b0;
    in_chan.time_q16 = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed words: extremes of the time range, the keys at 0, 6 and 12 s, just either side of a
    // key, the loop edge, negative wrap-around and every bit of the time word.
    send_time(32'sh0000_0000);
    send_time(32'sh7FFF_FFFF);
    send_time(32'sh8000_0000);
    send_time(-32'sd1);
    send_time(32'sd1);
    send_time(32'sd6 * 65536);
    send_time(32'sd6 * 65536 + 1);
    send_time(32'sd12 * 65536);
    send_time(32'sd18 * 65536 - 1);
    send_time(32'sd24 * 65536 - 1);
    send_time(32'sd24 * 65536);
    send_time(-32'sd24 * 65536);
    send_time(-32'sd3 * 65536);
    send_time(32'sd3 * 65536 + 32768);
    send_time(32'sh5555_5555);
    send_time(32'shAAAA_AAAA);

    // Back-pressure: the receiver holds off long enough for every stage to fill.
    fork
      long_hold_off(60);
      random_phase(40, 0, 0);
    join

    random_phase(220, 0, 0);
    random_phase(220, 87, 0);
    random_phase(220, 0, 87);
    random_phase(220, 30, 30);
    in_chan.valid <= 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;

    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("keyframe_track_interpolator regression: pass");
    end else begin
      $display("keyframe_track_interpolator regression: fail");
    end
    $finish;
  end

  // The slowest correct run finishes well before this limit, which leaves a wide margin.
  initial begin
    #400000;
    $display("keyframe_track_interpolator regression: fail");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/kti_pkg.sv
rtl/kti_in_if.sv
rtl/kti_out_if.sv
rtl/kti_wrap.sv
rtl/kti_sine.sv
rtl/kti_blend.sv
rtl/keyframe_track_interpolator.sv
tb/kti_tb_pkg.sv
tb/kti_tb_if.sv
tb/kti_pose_checker.sv
tb/tb.sv
